// File: hw/rtl/scaled_embedding_bag_sum_core_macros.svh
// assertion macros for the scaled embedding-bag sum core
`ifndef SCALED_EMBEDDING_BAG_SUM_CORE_MACROS_SVH
`define SCALED_EMBEDDING_BAG_SUM_CORE_MACROS_SVH

// checked while out of reset
`define SEBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define SEBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/sebs_pkg.sv
package sebs_pkg;

  localparam int MaxLanes = 8;
  localparam int DefLanes = 8;
  localparam int CfgAddrW = 4;

  localparam logic [31:0] ScaleReset = 32'h3F80_0000;
  localparam logic [31:0] QNan       = 32'h7FC0_0000;

  typedef enum logic [1:0] {
    REG_SCALE = 2'd0,
    REG_WFMT  = 2'd1,
    REG_OFMT  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    OFMT_FP32 = 2'd0,
    OFMT_INT8 = 2'd1,
    OFMT_FP8  = 2'd2
  } ofmt_e;

  typedef enum logic {
    WFMT_INT8 = 1'b0,
    WFMT_FP8  = 1'b1
  } wfmt_e;

  typedef struct packed {
    logic        last_of_bag;
    logic        first_of_bag;
    logic [63:0] weight_bytes;
  } in_item_t;

  typedef struct packed {
    logic [63:0] lanes_six_seven;
    logic [63:0] lanes_four_five;
    logic [63:0] lanes_two_three;
    logic [63:0] lanes_zero_one;
  } out_item_t;

  // scale unpacked and normalized
  typedef struct packed {
    logic              sign;
    logic              nan;
    logic              inf;
    logic              zero;
    logic signed [9:0] exp;
    logic [23:0]       man;
  } scale_t;

  typedef struct packed {
    logic ld_a;
    logic ld_b;
  } sc_ctrl_t;

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 5'(26 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// File: hw/rtl/sebs_lane.sv
module sebs_lane import sebs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  logic        first_i,
  input  logic        wfmt_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] sum_d_o
);

  function automatic logic [31:0] dec_int8(input logic [7:0] b);
    logic [7:0]  mag;
    logic [7:0]  norm;
    logic [4:0]  lz;
    logic [31:0] r;
    mag = b[7] ? (8'd0 - b) : b;
    lz  = lzc27({mag, 19'd0});
    norm = mag << lz;
    if (mag == 8'd0) begin
      r = 32'd0;
    end else begin
      r = {b[7], 8'd134 - 8'(lz), norm[6:0], 16'd0};
    end
    return r;
  endfunction

  function automatic logic [31:0] dec_fp8(input logic [7:0] b);
    logic [3:0]  e;
    logic [2:0]  m;
    logic [2:0]  norm;
    logic [4:0]  lz;
    logic [31:0] r;
    e    = b[6:3];
    m    = b[2:0];
    lz   = lzc27({m, 24'd0});
    norm = m << lz;
    if (e == 4'hF && m == 3'h7) begin
      r = QNan | {b[7], 31'd0};
    end else if (e == 4'd0) begin
      if (m == 3'd0) begin
        r = {b[7], 31'd0};
      end else begin
        r = {b[7], 8'd120 - 8'(lz), norm[1:0], 21'd0};
      end
    end else begin
      r = {b[7], 8'(e) + 8'd120, m, 20'd0};
    end
    return r;
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic        a_nan, b_nan, a_inf, b_inf;
    logic        sbig, ssml, sub, stk, rnd;
    logic [30:0] big, sml;
    logic [7:0]  eb, d;
    logic [26:0] mb, ms, msh;
    logic [27:0] s;
    logic [26:0] n;
    logic [4:0]  lz;
    logic [8:0]  e;
    logic [31:0] r;
    a_nan = (&a[30:23]) && (|a[22:0]);
    b_nan = (&b[30:23]) && (|b[22:0]);
    a_inf = (&a[30:23]) && !(|a[22:0]);
    b_inf = (&b[30:23]) && !(|b[22:0]);
    if (a[30:0] >= b[30:0]) begin
      big = a[30:0]; sbig = a[31]; sml = b[30:0]; ssml = b[31];
    end else begin
      big = b[30:0]; sbig = b[31]; sml = a[30:0]; ssml = a[31];
    end
    eb  = big[30:23];
    d   = eb - sml[30:23];
    mb  = {1'b1, big[22:0], 3'b000};
    ms  = {1'b1, sml[22:0], 3'b000};
    if (d > 8'd26) begin
      msh = 27'd0;
      stk = 1'b1;
    end else begin
      msh = ms >> d;
      stk = |(ms & ~(27'h7FF_FFFF << d));
    end
    msh[0] = msh[0] | stk;
    sub = sbig ^ ssml;
    s   = sub ? ({1'b0, mb} - {1'b0, msh}) : ({1'b0, mb} + {1'b0, msh});
    lz  = lzc27(s[26:0]);
    if (s[27]) begin
      n = {s[27:2], s[1] | s[0]};
      e = {1'b0, eb} + 9'd1;
    end else begin
      n = s[26:0] << lz;
      e = {1'b0, eb} - 9'(lz);
    end
    rnd = n[2] & (n[1] | n[0] | n[3]);
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      r = QNan;
    end else if (a_inf) begin
      r = a;
    end else if (b_inf) begin
      r = b;
    end else if (sml[30:23] == 8'd0) begin
      r = (eb == 8'd0) ? {sbig & ssml, 31'd0} : {sbig, big};
    end else if (s == 28'd0) begin
      r = 32'd0;
    end else if (!s[27] && ({1'b0, eb} <= 9'(lz))) begin
      r = {sbig, 31'd0};
    end else if (e >= 9'd255) begin
      r = {sbig, 8'hFF, 23'd0};
    end else begin
      r = {sbig, 31'({e[7:0], n[25:3]}) + 31'(rnd)};
    end
    return r;
  endfunction

  logic [31:0] val;
  logic [31:0] sum_d, sum_q;

  always_comb begin
    val   = (wfmt_i == WFMT_FP8) ? dec_fp8(byte_i) : dec_int8(byte_i);
    sum_d = first_i ? val : fadd(sum_q, val);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= 32'd0;
    end else if (acc_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_d_o = sum_d;

endmodule

// File: hw/rtl/sebs_scale.sv
module sebs_scale import sebs_pkg::*; (
  input  logic        clk_i,
  input  sc_ctrl_t    ctrl_i,
  input  logic [31:0] sum_i,
  input  scale_t      scl_i,
  input  logic [1:0]  ofmt_i,
  output logic [31:0] code_o
);

  function automatic logic [23:0] rne_shr(input logic [23:0] v, input logic [4:0] sh);
    logic [23:0] q;
    logic [24:0] rem, half;
    q    = v >> sh;
    rem  = {1'b0, v} - {1'b0, 24'(q << sh)};
    half = 25'd1 << (sh - 5'd1);
    if (rem > half || (rem == half && q[0])) begin
      q = q + 24'd1;
    end
    return q;
  endfunction

  function automatic logic [7:0] enc_fp8(input logic [31:0] u);
    logic [7:0]  ex;
    logic [22:0] man;
    logic [6:0]  code;
    logic [7:0]  sh;
    logic [23:0] q;
    ex   = u[30:23];
    man  = u[22:0];
    sh   = 8'd141 - ex;
    q    = rne_shr({1'b1, man}, sh[4:0]);
    code = {4'(ex - 8'd120), man[22:20]};
    if (u[30:0] >= 31'h43F0_0000) begin
      code = 7'h7F;
    end else if (ex < 8'd121) begin
      code = (ex == 8'd0 || sh > 8'd25) ? 7'd0 : q[6:0];
    end else if (man[19:0] > 20'h80000 || (man[19:0] == 20'h80000 && code[0])) begin
      code = code + 7'd1;
    end
    return {u[31], code};
  endfunction

  function automatic logic [7:0] enc_int8(input logic [31:0] u);
    logic [7:0]  ex;
    logic [23:0] mag;
    logic [7:0]  r;
    ex  = u[30:23];
    mag = rne_shr({1'b1, u[22:0]}, 5'(8'd150 - ex));
    if (ex == 8'hFF && u[22:0] != 23'd0) begin
      r = 8'h80;
    end else if (ex >= 8'd135) begin
      r = u[31] ? 8'h80 : 8'h7F;
    end else if (ex < 8'd126) begin
      r = 8'h00;
    end else if (u[31]) begin
      r = (mag >= 24'd128) ? 8'h80 : (8'd0 - mag[7:0]);
    end else begin
      r = (mag > 24'd127) ? 8'h7F : mag[7:0];
    end
    return r;
  endfunction

  // multiply stage
  logic [7:0]         ea;
  logic               s_nan, s_inf, s_zero;
  logic [47:0]        a_prod_q;
  logic signed [10:0] a_exp_d, a_exp_q;
  logic               a_sign_q, a_nan_q, a_inf_q, a_zero_q;

  always_comb begin
    ea      = sum_i[30:23];
    s_nan   = (ea == 8'hFF) && (sum_i[22:0] != 23'd0);
    s_inf   = (ea == 8'hFF) && (sum_i[22:0] == 23'd0);
    s_zero  = (ea == 8'd0);
    a_exp_d = $signed({3'b000, ea}) + $signed({scl_i.exp[9], scl_i.exp}) - 11'sd127;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_a) begin
      a_prod_q <= {1'b1, sum_i[22:0]} * scl_i.man;
      a_exp_q  <= a_exp_d;
      a_sign_q <= sum_i[31] ^ scl_i.sign;
      a_nan_q  <= s_nan || scl_i.nan || (s_inf && scl_i.zero) || (scl_i.inf && s_zero);
      a_inf_q  <= s_inf || scl_i.inf;
      a_zero_q <= s_zero || scl_i.zero;
    end
  end

  // round stage
  logic [47:0]        m, sm;
  logic signed [10:0] e1, t;
  logic [5:0]         sh;
  logic [7:0]         ex;
  logic               stk, rnd;
  logic [30:0]        mag;
  logic [31:0]        b_bits_d, b_bits_q;

  always_comb begin
    m   = a_prod_q[47] ? a_prod_q : (a_prod_q << 1);
    e1  = a_prod_q[47] ? (a_exp_q + 11'sd1) : a_exp_q;
    t   = 11'sd1 - e1;
    if (e1 >= 11'sd1) begin
      sh = 6'd0;
      ex = e1[7:0];
    end else begin
      sh = (t > 11'sd63) ? 6'd63 : t[5:0];
      ex = 8'd0;
    end
    sm  = m >> sh;
    stk = (sm << sh) != m;
    rnd = sm[23] & ((|sm[22:0]) | stk | sm[24]);
    mag = {ex, sm[46:24]} + 31'(rnd);
    if (a_nan_q) begin
      b_bits_d = QNan;
    end else if (a_inf_q || (e1 >= 11'sd255 && !a_zero_q)) begin
      b_bits_d = {a_sign_q, 8'hFF, 23'd0};
    end else if (a_zero_q) begin
      b_bits_d = {a_sign_q, 31'd0};
    end else begin
      b_bits_d = {a_sign_q, mag};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_b) begin
      b_bits_q <= b_bits_d;
    end
  end

  always_comb begin
    case (ofmt_i)
      OFMT_INT8: code_o = {24'd0, enc_int8(b_bits_q)};
      OFMT_FP8:  code_o = {24'd0, enc_fp8(b_bits_q)};
      default:   code_o = b_bits_q;
    endcase
  end

endmodule

// File: hw/rtl/scaled_embedding_bag_sum_core.sv
// Scaled embedding-bag sum, LANES lanes of one row slice per item.
// Input channel (in_valid_i/in_stall_o/in_data_i): one chunk of packed weight
// bytes per item; first_of_bag restarts the lane sums, last_of_bag closes the
// bag. Output channel (out_valid_o/out_stall_i/out_data_o): one item per
// closed bag with every lane scaled and encoded as fp32, int8 or fp8.
// Throughput: one item per cycle while in_stall_o is low; each lane adds its
// decoded byte into its fp32 sum through a combinational adder, and that
// loop sets the rate. A closing item is captured in the sum snapshot at the
// accepting edge, then passes the multiply and round registers and is encoded
// into the output register.
// A stalled output holds; once the snapshot, multiply, round and output
// stages are all full, in_stall_o rises until the output drains.
// Reset clears the lane sums to +0, empties the pipeline and loads the
// registers with scale 1.0, int8 weights and fp32 output. Registers sit on the
// APB port at byte addresses 0 (scale), 4 (weight format), 8 (output format);
// the user must write them only while no item is in flight (not enforced).
module scaled_embedding_bag_sum_core import sebs_pkg::*; #(
  parameter int LANES = DefLanes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [31:0] scale_q;
  logic        wfmt_q;
  logic [1:0]  ofmt_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
      wfmt_q  <= WFMT_INT8;
      ofmt_q  <= OFMT_FP32;
    end else if (wr) begin
      unique case (reg_idx_e'(paddr[CfgAddrW-1:2]))
        REG_SCALE: scale_q <= pwdata;
        REG_WFMT:  wfmt_q  <= pwdata[0];
        REG_OFMT:  ofmt_q  <= pwdata[1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[CfgAddrW-1:2]))
      REG_SCALE: prdata = scale_q;
      REG_WFMT:  prdata = {31'd0, wfmt_q};
      REG_OFMT:  prdata = {30'd0, ofmt_q};
      default:   prdata = 32'd0;
    endcase
  end

  // scale unpacked once, subnormals normalized
  scale_t     scl_d, scl_q;
  logic [4:0] scl_lz;

  always_comb begin
    scl_lz     = lzc27({scale_q[22:0], 4'd0});
    scl_d.sign = scale_q[31];
    scl_d.nan  = (scale_q[30:23] == 8'hFF) && (scale_q[22:0] != 23'd0);
    scl_d.inf  = (scale_q[30:23] == 8'hFF) && (scale_q[22:0] == 23'd0);
    scl_d.zero = (scale_q[30:0] == 31'd0);
    if (scale_q[30:23] != 8'd0) begin
      scl_d.man = {1'b1, scale_q[22:0]};
      scl_d.exp = $signed({2'b00, scale_q[30:23]});
    end else begin
      scl_d.man = {1'b0, scale_q[22:0]} << (scl_lz + 5'd1);
      scl_d.exp = -$signed({5'd0, scl_lz});
    end
  end

  always_ff @(posedge clk_i) begin
    scl_q <= scl_d;
  end

  // handshake and stage occupancy
  logic     v1_q, v2_q, v3_q, vo_q;
  logic     rdy1, rdy2, rdy3, rdyo;
  logic     acc;
  sc_ctrl_t ctrl;

  assign rdyo       = !vo_q || !out_stall_i;
  assign rdy3       = !v3_q || rdyo;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;
  assign acc        = in_valid_i && rdy1;
  assign ctrl.ld_a  = rdy2 && v1_q;
  assign ctrl.ld_b  = rdy3 && v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= acc && in_data_i.last_of_bag;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  logic [31:0] lane_word [MaxLanes];

  for (genvar k = 0; k < MaxLanes; k++) begin : g_lane
    if (k < LANES) begin : g_on
      logic [31:0] sum_d;
      logic [31:0] snap_q;

      sebs_lane u_lane (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .acc_i   (acc),
        .first_i (in_data_i.first_of_bag),
        .wfmt_i  (wfmt_q),
        .byte_i  (in_data_i.weight_bytes[8*k +: 8]),
        .sum_d_o (sum_d)
      );

      always_ff @(posedge clk_i) begin
        if (acc && in_data_i.last_of_bag) begin
          snap_q <= sum_d;
        end
      end

      sebs_scale u_scale (
        .clk_i  (clk_i),
        .ctrl_i (ctrl),
        .sum_i  (snap_q),
        .scl_i  (scl_q),
        .ofmt_i (ofmt_q),
        .code_o (lane_word[k])
      );
    end else begin : g_off
      assign lane_word[k] = 32'd0;
    end
  end

  // merge lanes into the result item
  out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (rdyo && v3_q) begin
      out_q.lanes_zero_one  <= {lane_word[1], lane_word[0]};
      out_q.lanes_two_three <= {lane_word[3], lane_word[2]};
      out_q.lanes_four_five <= {lane_word[5], lane_word[4]};
      out_q.lanes_six_seven <= {lane_word[7], lane_word[6]};
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/sebs_chk.sv
`include "scaled_embedding_bag_sum_core_macros.svh"

module sebs_chk import sebs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  `SEBS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled output item changed")
  `SEBS_ASSERT(a_stall_src, in_stall_o |-> out_valid_o && out_stall_i, "input stalled while output drains")
  `SEBS_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> !out_valid_o, "output valid during reset")
  `SEBS_ASSERT(a_rst_free, $rose(rst_ni) |-> !in_stall_o, "input stalled right after reset")

endmodule

bind scaled_embedding_bag_sum_core sebs_chk u_sebs_chk (.*);

// File: tb/sv/tb_top.sv
module tb_top;
  import sebs_pkg::*;

  localparam logic [1:0] OFMT_UNUSED = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 12;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  scaled_embedding_bag_sum_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // predictor state
  logic [31:0] lane_sum_bits [MaxLanes];
  logic [31:0] cfg_scale;
  wfmt_e       cfg_wfmt;
  logic [1:0]  cfg_ofmt;

  in_item_t  chunk_q [$];
  out_item_t bag_results_q [$];
  int unsigned fail_count;
  int unsigned cycle_count;

  function automatic real f32_to_real(logic [31:0] b);
    logic [63:0] d;
    if (b[30:23] == 8'd0) begin
      return (b[31] ? -1.0 : 1.0) * real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
    end
    if (b[30:23] == 8'hFF) d = {b[31], 11'h7FF, b[22:0], 29'd0};
    else d = {b[31], 11'(b[30:23] + 11'd896), b[22:0], 29'd0};
    return $bitstoreal(d);
  endfunction

  // double to fp32 with round to nearest even
  function automatic logic [31:0] real_to_f32(real r);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic        sgn;
    int          x;
    int          sh;
    d   = $realtobits(r);
    sgn = d[63];
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? QNan : {sgn, 8'hFF, 23'd0};
    if (d[62:52] == 11'd0) return {sgn, 31'd0};
    x   = int'(d[62:52]) - 1023;
    sig = {11'd0, 1'b1, d[51:0]};
    if (x > 127) return {sgn, 8'hFF, 23'd0};
    if (x >= -126) begin
      q    = sig >> 29;
      rem  = sig & ((64'd1 << 29) - 1);
      half = 64'd1 << 28;
      if (rem > half || (rem == half && q[0])) q = q + 1;
      if (q[24]) begin
        q = q >> 1;
        x = x + 1;
      end
      if (x > 127) return {sgn, 8'hFF, 23'd0};
      return {sgn, 8'(x + 127), q[22:0]};
    end
    sh = -x - 97;
    if (sh > 54) return {sgn, 31'd0};
    q    = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    return {sgn, q[30:0]};
  endfunction

  function automatic logic [31:0] weight_to_f32(logic [7:0] b, wfmt_e fmt);
    logic [31:0] m;
    if (fmt == WFMT_INT8) return real_to_f32(real'($signed(b)));
    if (b[6:0] == 7'h7F) return QNan | {b[7], 31'd0};
    if (b[6:3] == 4'd0) begin
      m = real_to_f32(real'(b[2:0]) / 512.0);
      return m | {b[7], 31'd0};
    end
    return {b[7], 8'(b[6:3] + 8'd120), b[2:0], 20'd0};
  endfunction

  function automatic logic [7:0] to_int8(logic [31:0] pb);
    real v;
    real frac;
    int  t;
    v = f32_to_real(pb);
    if (pb == QNan || v <= -128.5) return 8'h80;
    if (v >= 127.5) return 8'h7F;
    t    = $rtoi(v);
    frac = v - real'(t);
    if (frac > 0.5 || (frac == 0.5 && t[0])) t = t + 1;
    else if (frac < -0.5 || (frac == -0.5 && t[0])) t = t - 1;
    if (t > 127) t = 127;
    if (t < -128) t = -128;
    return t[7:0];
  endfunction

  function automatic logic [7:0] to_fp8(logic [31:0] u);
    logic [30:0] a;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [31:0] m24;
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] half;
    logic [7:0]  code;
    int          sh;
    a   = u[30:0];
    ex  = a[30:23];
    man = a[22:0];
    if (a >= 31'h43F0_0000) begin
      code = 8'h7F;
    end else if (ex < 8'd121) begin
      if (ex == 8'd0) begin
        code = 8'd0;
      end else begin
        m24 = {8'd0, 1'b1, man};
        sh  = 141 - int'(ex);
        if (sh > 25) begin
          code = 8'd0;
        end else begin
          q    = m24 >> sh;
          rem  = m24 & ((32'd1 << sh) - 1);
          half = 32'd1 << (sh - 1);
          if (rem > half || (rem == half && q[0])) q = q + 1;
          code = q[7:0];
        end
      end
    end else begin
      code = {5'(ex - 8'd120), man[22:20]};
      if (man[19:0] > 20'h80000 || (man[19:0] == 20'h80000 && code[0])) code = code + 8'd1;
    end
    return code | {u[31], 7'd0};
  endfunction

  task automatic accumulate_chunk(input in_item_t it);
    logic [31:0] v;
    logic [31:0] pb;
    logic [31:0] r;
    out_item_t   res;
    logic [255:0] flat;
    for (int k = 0; k < MaxLanes; k++) begin
      v = weight_to_f32(it.weight_bytes[8*k +: 8], cfg_wfmt);
      if (it.first_of_bag) lane_sum_bits[k] = v;
      else lane_sum_bits[k] = real_to_f32(f32_to_real(lane_sum_bits[k]) + f32_to_real(v));
    end
    if (!it.last_of_bag) return;
    flat = '0;
    for (int k = 0; k < MaxLanes; k++) begin
      pb = real_to_f32(f32_to_real(lane_sum_bits[k]) * f32_to_real(cfg_scale));
      if (pb[30:23] == 8'hFF && pb[22:0] != 0) pb = QNan;
      if (cfg_ofmt == OFMT_INT8) r = {24'd0, to_int8(pb)};
      else if (cfg_ofmt == OFMT_FP8) r = {24'd0, to_fp8(pb)};
      else r = pb;
      flat[32*k +: 32] = r;
    end
    res.lanes_zero_one  = flat[63:0];
    res.lanes_two_three = flat[127:64];
    res.lanes_four_five = flat[191:128];
    res.lanes_six_seven = flat[255:192];
    bag_results_q.push_back(res);
  endtask

  // sender: bursts with gaps
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left != 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        in_valid_i <= 1'b0;
      end else if (chunk_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= chunk_q.pop_front();
        burst_left <= burst_left - 1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall rate redrawn from 0, 20, 50 or 85 percent
  int unsigned stall_pct;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_pct   <= 0;
    end else begin
      if (cycle_count % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct <= 0;
          1: stall_pct <= 20;
          2: stall_pct <= 50;
          default: stall_pct <= 85;
        endcase
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) accumulate_chunk(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        if (bag_results_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_o);
          fail_count++;
        end else begin
          want = bag_results_q.pop_front();
          if (want.lanes_zero_one !== out_data_o.lanes_zero_one) begin
            $display("%0t: lanes_zero_one exp %h got %h", $time, want.lanes_zero_one,
                     out_data_o.lanes_zero_one);
            fail_count++;
          end
          if (want.lanes_two_three !== out_data_o.lanes_two_three) begin
            $display("%0t: lanes_two_three exp %h got %h", $time, want.lanes_two_three,
                     out_data_o.lanes_two_three);
            fail_count++;
          end
          if (want.lanes_four_five !== out_data_o.lanes_four_five) begin
            $display("%0t: lanes_four_five exp %h got %h", $time, want.lanes_four_five,
                     out_data_o.lanes_four_five);
            fail_count++;
          end
          if (want.lanes_six_seven !== out_data_o.lanes_six_seven) begin
            $display("%0t: lanes_six_seven exp %h got %h", $time, want.lanes_six_seven,
                     out_data_o.lanes_six_seven);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL scaled_embedding_bag_sum_core");
      $finish;
    end
  end

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SCALE: cfg_scale = val;
      REG_WFMT:  cfg_wfmt = wfmt_e'(val[0]);
      default:   cfg_ofmt = val[1:0];
    endcase
  endtask

  task automatic set_config(input logic [31:0] scale, input wfmt_e wf, input logic [1:0] of);
    reg_write(REG_SCALE, scale);
    reg_write(REG_WFMT, {31'd0, wf});
    reg_write(REG_OFMT, {30'd0, of});
  endtask

  task automatic drain();
    while (chunk_q.size() != 0 || in_valid_i || bag_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic push_chunk(input logic [63:0] w, input logic f, input logic l);
    in_item_t it;
    it.weight_bytes = w;
    it.first_of_bag = f;
    it.last_of_bag  = l;
    chunk_q.push_back(it);
  endtask

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return ScaleReset;
      2: return {1'($urandom_range(0, 1)), 8'($urandom_range(110, 140)), 23'($urandom())};
      3: return {1'b0, 8'($urandom_range(118, 128)), 23'd0};
      4: return {1'($urandom_range(0, 1)), 8'($urandom_range(120, 134)), 23'($urandom())};
      default: return {1'b0, 8'($urandom_range(125, 129)), 23'($urandom())};
    endcase
  endfunction

  function automatic logic [63:0] rand_weights();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    if ($urandom_range(0, 3) == 0) begin
      for (int k = 0; k < MaxLanes; k++) begin
        if ($urandom_range(0, 1) == 0) w[8*k +: 8] = 8'($urandom_range(0, 7));
      end
    end
    return w;
  endfunction

  initial begin
    int unsigned made;
    int unsigned len;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    fail_count  = 0;
    cycle_count = 0;
    cfg_scale   = ScaleReset;
    cfg_wfmt    = WFMT_INT8;
    cfg_ofmt    = OFMT_FP32;
    for (int k = 0; k < MaxLanes; k++) lane_sum_bits[k] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: chunk without first flag, sums kept after last
    push_chunk(64'h7F80_FF00_017F_8001, 1'b0, 1'b1);
    push_chunk(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
    push_chunk(64'h8080_8080_8080_8080, 1'b1, 1'b0);
    push_chunk(64'h7F7F_7F7F_7F7F_7F7F, 1'b0, 1'b1);
    drain();

    set_config(ScaleReset, WFMT_FP8, OFMT_FP32);
    push_chunk(64'h7FFF_7E80_0108_FE07, 1'b1, 1'b1);
    push_chunk(64'h7E7E_FEFE_7700_8001, 1'b0, 1'b1);
    drain();

    set_config(32'h7F7F_FFFF, WFMT_FP8, OFMT_FP8);
    push_chunk(64'h7E01_8008_FE00_3877, 1'b1, 1'b1);
    drain();
    set_config(32'h43E8_0000, WFMT_FP8, OFMT_FP8);
    push_chunk(64'h3840_BAC8_0102_0304, 1'b1, 1'b1);
    drain();

    set_config(32'h3F00_0000, WFMT_INT8, OFMT_INT8);
    push_chunk(64'h0103_FFFD_057F_8002, 1'b1, 1'b1);
    drain();
    set_config(32'h4200_0000, WFMT_INT8, OFMT_INT8);
    push_chunk(64'h7F80_0405_FCFB_0100, 1'b1, 1'b1);
    drain();

    set_config(32'hFFFF_FFFF, WFMT_FP8, OFMT_UNUSED);
    push_chunk(64'h0102_0304_0506_0708, 1'b1, 1'b1);
    drain();
    set_config(32'h0000_0001, WFMT_FP8, OFMT_INT8);
    push_chunk(64'h7F01_8877_0000_FF7E, 1'b1, 1'b1);
    drain();
    set_config(32'h0000_0000, WFMT_FP8, OFMT_FP8);
    push_chunk(64'h7F00_7E00_FE00_0100, 1'b1, 1'b1);
    drain();

    made = 0;
    while (made < 600) begin
      set_config(pick_scale(), wfmt_e'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(0, 6) == 0) begin
          push_chunk(rand_weights(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          made++;
        end else begin
          len = $urandom_range(1, 6);
          for (int m = 0; m < len; m++) begin
            push_chunk(rand_weights(), m == 0, m == len - 1);
          end
          made += len;
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS scaled_embedding_bag_sum_core");
    end else begin
      $display("FAIL scaled_embedding_bag_sum_core");
    end
    $finish;
  end

endmodule
